### hdl/srs_pkg.sv
// Shared types and constants for the substring removal stream block.
// No dependencies; the core, the cell and the queue refer to this package.
package srs_pkg;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH  = 2'd1;

  localparam int PAT_W   = 64;
  localparam int LEN_W   = 4;
  localparam int COUNT_W = 16;

  // One result request as it leaves the block
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_present;
    logic               out_last;
    logic [COUNT_W-1:0] removed_count;
  } res_t;

  // Common control that the sequencer hands to every window cell
  typedef struct packed {
    logic       adv;       // cells take their next value
    logic       shift;     // each cell takes its right neighbor's byte
    logic [7:0] ins_byte;  // byte being appended this cycle
  } cell_ctrl_t;

endpackage

### hdl/srs_in_if.sv
// Input channel of the substring removal stream block: one byte per request.
// No dependencies.
interface srs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_last;

  modport source (output valid, data_byte, in_last, input ready);
  modport sink (input valid, data_byte, in_last, output ready);
endinterface

### hdl/srs_out_if.sv
// Result channel of the substring removal stream block.
// No dependencies.
interface srs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_present;
  logic        out_last;
  logic [15:0] removed_count;

  modport source (output valid, out_byte, byte_present, out_last, removed_count, input ready);
  modport sink (input valid, out_byte, byte_present, out_last, removed_count, output ready);
endinterface

### hdl/srs_cfg_if.sv
// Configuration write channel of the substring removal stream block.
// No dependencies.
interface srs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [63:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

### hdl/substring_removal_stream_core.sv
// Substring removal stream: deletes every leftmost, non-overlapping match of a
// configured pattern from a byte stream.
// Channels: in_chan takes one byte per request with in_last on the final byte
// of a string; out_chan gives kept bytes and, on out_last, the removal count
// (saturating at 65535); a string with nothing kept ends in one bare marker
// with byte_present low. cfg_chan writes the pattern (index 0, first byte in
// the low bits) and its length (index 1, zero passes bytes through, above
// MAX_PATTERN acts as MAX_PATTERN); cfg_chan is always ready; the user must
// make writes only between requests, which the block does not enforce.
// Throughput: one byte per cycle while the sequencer is not busy and the queue
// has room. The window is a row of MAX_PATTERN cells compared in parallel; the
// sequencer does one window step per cycle while the queue has room. After a
// final byte it lets out the remaining bytes or removes a match it completes,
// then sends the end marker; after a length cut it lets out the surplus bytes
// before the compare. Results pass through the queue registers to out_chan.
// A two-entry result queue lets input requests continue while a result waits;
// when it is full the sequencer and in_chan.ready stop until out_chan drains.
// Reset clears the window fill, count and queue and both config registers.
// Depends on srs_pkg, srs_in_if, srs_out_if, srs_cfg_if, srs_cell, srs_outq.
module substring_removal_stream_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic      clk,
  input  logic      rst,
  srs_in_if.sink    in_chan,
  srs_out_if.source out_chan,
  srs_cfg_if.sink   cfg_chan
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  // Sequencer step codes
  localparam logic [1:0] STEP_NONE  = 2'd0;
  localparam logic [1:0] STEP_EMIT  = 2'd1;
  localparam logic [1:0] STEP_MATCH = 2'd2;
  localparam logic [1:0] STEP_FINAL = 2'd3;

  // Configuration registers
  logic [srs_pkg::PAT_W-1:0] pattern;
  logic [srs_pkg::LEN_W-1:0] pat_len;

  // Sequencer state
  logic                        busy;
  logic                        last_item;
  logic [FILL_W-1:0]           fill;
  logic [srs_pkg::COUNT_W-1:0] tally;
  logic                        hold_valid;
  logic [7:0]                  hold_byte;

  logic                        busy_next;
  logic                        last_item_next;
  logic [FILL_W-1:0]           fill_next;
  logic [srs_pkg::COUNT_W-1:0] tally_next;
  logic                        hold_valid_next;
  logic [7:0]                  hold_byte_next;

  logic                 room;
  logic                 accept;
  logic                 adv;
  logic [FILL_W-1:0]    len_eff;
  logic [FILL_W-1:0]    cur_fill;
  logic                 cur_last;
  logic [1:0]           step;
  logic                 match_all;
  logic                 push;
  srs_pkg::res_t        push_data;
  srs_pkg::cell_ctrl_t  cell_ctrl;

  logic [7:0]             view [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] ins;

  // Configuration writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      pat_len <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        srs_pkg::CFG_PATTERN: pattern <= cfg_chan.wdata;
        srs_pkg::CFG_LENGTH:  pat_len <= cfg_chan.wdata[srs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to the cell count
  assign len_eff = (pat_len > srs_pkg::LEN_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                            : FILL_W'(pat_len);

  // Handshake: a new byte enters only when the previous one is finished
  assign in_chan.ready = !busy && room;
  assign accept        = in_chan.valid && in_chan.ready;
  assign adv           = room && (busy || accept);

  // Window as seen this cycle, with any new byte appended
  assign cur_fill = accept ? fill + FILL_W'(1) : fill;
  assign cur_last = accept ? in_chan.in_last : last_item;

  // Row of window cells, oldest byte in cell 0
  assign cell_ctrl.adv      = adv;
  assign cell_ctrl.shift    = (step == STEP_EMIT);
  assign cell_ctrl.ins_byte = in_chan.data_byte;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] right;
    if (i == MAX_PATTERN - 1) begin : g_end
      assign right = 8'h00;
    end else begin : g_mid
      assign right = view[i+1];
    end
    assign ins[i] = accept && (fill == FILL_W'(i));
    srs_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .ins        (ins[i]),
      .pat_byte   (pattern[8*i +: 8]),
      .right_view (right),
      .view       (view[i]),
      .eq         (eq[i])
    );
  end

  // Whole-window compare over the active cells
  always_comb begin
    match_all = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((FILL_W'(k) < len_eff) && !eq[k]) begin
        match_all = 1'b0;
      end
    end
  end

  // Pick the step: surplus bytes first, then the compare, then the end flush
  always_comb begin
    priority if (cur_fill > len_eff) begin
      step = STEP_EMIT;
    end else if ((len_eff != '0) && (cur_fill == len_eff)) begin
      step = match_all ? STEP_MATCH : STEP_EMIT;
    end else if (cur_last && (cur_fill != '0)) begin
      step = STEP_EMIT;
    end else if (cur_last) begin
      step = STEP_FINAL;
    end else begin
      step = STEP_NONE;
    end
  end

  // Next state and result request
  always_comb begin
    fill_next       = cur_fill;
    tally_next      = tally;
    hold_valid_next = hold_valid;
    hold_byte_next  = hold_byte;
    last_item_next  = cur_last;
    push            = 1'b0;
    push_data       = '0;
    unique case (step)
      STEP_EMIT: begin
        fill_next = cur_fill - FILL_W'(1);
        if (cur_last) begin
          // Hold back one byte so the final one can carry the end marker
          push                   = hold_valid;
          push_data.out_byte     = hold_byte;
          push_data.byte_present = 1'b1;
          hold_valid_next        = 1'b1;
          hold_byte_next         = view[0];
        end else begin
          push                   = 1'b1;
          push_data.out_byte     = view[0];
          push_data.byte_present = 1'b1;
        end
      end
      STEP_MATCH: begin
        fill_next  = '0;
        tally_next = (tally != '1) ? tally + srs_pkg::COUNT_W'(1) : tally;
      end
      STEP_FINAL: begin
        push                    = 1'b1;
        push_data.out_byte      = hold_valid ? hold_byte : 8'h00;
        push_data.byte_present  = hold_valid;
        push_data.out_last      = 1'b1;
        push_data.removed_count = tally;
        fill_next               = '0;
        tally_next              = '0;
        hold_valid_next         = 1'b0;
        last_item_next          = 1'b0;
      end
      default: ;
    endcase

    // More steps remain while surplus or a pending compare or end is left
    if (step == STEP_FINAL) begin
      busy_next = 1'b0;
    end else begin
      busy_next = cur_last || (fill_next > len_eff) ||
                  ((len_eff != '0) && (fill_next == len_eff));
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      last_item  <= 1'b0;
      fill       <= '0;
      tally      <= '0;
      hold_valid <= 1'b0;
    end else if (adv) begin
      busy       <= busy_next;
      last_item  <= last_item_next;
      fill       <= fill_next;
      tally      <= tally_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hold_byte <= hold_byte_next;
    end
  end

  // Result queue
  srs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push && adv),
    .push_data (push_data),
    .room      (room),
    .out_chan  (out_chan)
  );

  // Between requests the window never holds a full pattern
  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (fill < FILL_W'(MAX_PATTERN)))
    else $error("window fill too large while idle");

  // A held byte only exists while a final byte is being flushed
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (busy && last_item))
    else $error("held byte outside an end flush");

  // The end of a string leaves a clean window and count
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && (step == STEP_FINAL)) |=> (!busy && (fill == '0) && (tally == '0)))
    else $error("state not cleared after end of string");

  // The sequencer does not advance while a result cannot be queued
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (busy && !room) |=> $stable(fill) && $stable(tally))
    else $error("sequencer advanced without queue room");

endmodule

### hdl/srs_cell.sv
// One window cell: holds a byte, compares it with its pattern byte and
// shifts toward the oldest end. Depends on srs_pkg.
module srs_cell (
  input  logic                   clk,
  input  srs_pkg::cell_ctrl_t    ctrl,
  input  logic                   ins,
  input  logic [7:0]             pat_byte,
  input  logic [7:0]             right_view,
  output logic [7:0]             view,
  output logic                   eq
);

  logic [7:0] q;

  // Byte as seen this cycle, including one being appended here
  assign view = ins ? ctrl.ins_byte : q;
  assign eq   = (view == pat_byte);

  // Shift in the neighbor's byte or keep the current view
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      q <= ctrl.shift ? right_view : view;
    end
  end

endmodule

### hdl/srs_outq.sv
// Two-entry result queue between the sequencer and the result channel.
// Depends on srs_pkg and srs_out_if.
module srs_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srs_pkg::res_t push_data,
  output logic          room,
  srs_out_if.source     out_chan
);

  localparam int DEPTH = 2;

  srs_pkg::res_t mem [DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop  = out_chan.valid && out_chan.ready;
  assign room = (count < 2'(DEPTH));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign out_chan.valid         = (count != 2'd0);
  assign out_chan.out_byte      = mem[rd_ptr].out_byte;
  assign out_chan.byte_present  = mem[rd_ptr].byte_present;
  assign out_chan.out_last      = mem[rd_ptr].out_last;
  assign out_chan.removed_count = mem[rd_ptr].removed_count;

endmodule
